FILE: rtl/channel_matrix_mixer_unit_macros.svh
// Assertion macros used by the checker file of the matrix mixer, cmm_checker.sv.
// No dependencies; every macro expects signals named clk and rst_n in scope.
`ifndef CHANNEL_MATRIX_MIXER_UNIT_MACROS_SVH
`define CHANNEL_MATRIX_MIXER_UNIT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define CMM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define CMM_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/cmm_pkg.sv
// Shared constants, types and arithmetic helpers of the matrix mixer.
// No dependencies; imported by every module of the block except cmm_ram.
package cmm_pkg;

    localparam int IN_CHANNELS  = 8;
    localparam int OUT_CHANNELS = 8;
    localparam int SAMPLE_BITS  = 24;
    localparam int GAIN_BITS    = 16;

    localparam int FRAC_BITS    = GAIN_BITS - 2;
    localparam int PROD_BITS    = SAMPLE_BITS + GAIN_BITS;
    localparam int ACC_BITS     = SAMPLE_BITS + GAIN_BITS + 3;
    localparam int GAIN_DEPTH   = IN_CHANNELS * OUT_CHANNELS;
    localparam int GAIN_AW      = $clog2(GAIN_DEPTH);
    localparam int CH_W         = 3;
    localparam int COUNT_W      = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 4;
    localparam int DRAIN_CYCLES = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NUM_INPUTS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_OUTPUTS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMPLEX_MODE = 2'd2;

    // Item function codes.
    localparam logic FUNC_GAIN   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic               gain_wr;
        logic               clear_wr;
        logic [GAIN_AW-1:0] clear_addr;
        logic               load_item;
        logic               mac_rd;
        logic [CH_W-1:0]    row;
        logic               emit;
        logic               emit_last;
        logic               acc_clear;
        logic               complex_mode;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

    function automatic logic [GAIN_AW-1:0] gain_addr(input logic [CH_W-1:0] row,
                                                     input logic [CH_W-1:0] col);
        return GAIN_AW'(row * IN_CHANNELS + col);
    endfunction

    // Accumulate with saturation to the signed accumulator range.
    function automatic logic signed [ACC_BITS-1:0] sat_add(
        input logic signed [ACC_BITS-1:0]  a,
        input logic signed [PROD_BITS-1:0] p
    );
        logic signed [ACC_BITS:0] s;
        s = (ACC_BITS+1)'(a) + (ACC_BITS+1)'(p);
        if (s[ACC_BITS] != s[ACC_BITS-1])
        begin
            return s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
        end
        return s[ACC_BITS-1:0];
    endfunction

    // Round half up by the gain fraction, then saturate to the sample width.
    function automatic logic [SAMPLE_BITS-1:0] to_output(input logic signed [ACC_BITS-1:0] acc);
        logic signed [ACC_BITS:0]           r;
        logic signed [ACC_BITS-FRAC_BITS:0] q;
        logic signed [ACC_BITS:0]           half;
        half = (ACC_BITS+1)'(1) <<< (FRAC_BITS - 1);
        r    = (ACC_BITS+1)'(acc) + half;
        q    = r[ACC_BITS:FRAC_BITS];
        if (q[ACC_BITS-FRAC_BITS:SAMPLE_BITS-1] != {(ACC_BITS-FRAC_BITS-SAMPLE_BITS+2){1'b0}} &&
            q[ACC_BITS-FRAC_BITS:SAMPLE_BITS-1] != {(ACC_BITS-FRAC_BITS-SAMPLE_BITS+2){1'b1}})
        begin
            return q[ACC_BITS-FRAC_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                         : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return q[SAMPLE_BITS-1:0];
    endfunction

endpackage

FILE: rtl/channel_matrix_mixer_unit.sv
// Top level of the channel matrix mixer: controller plus datapath.
// Depends on cmm_pkg, cmm_ctrl, cmm_datapath (and through it cmm_ram).
//
// Usage:
// The input channel takes one beat per item. A gain beat (func = 0) stores one
// Q2.14 gain at row out_row, column in_channel and leaves the block idle.
// A sample beat (func = 1) carries one input channel's Q1.23 sample; its channel
// must be below num_inputs or it is dropped without a result.
// Each accepted sample runs a multiply-accumulate pass over all eight output
// rows through the one gain memory read port, then drains the read data and
// product registers; the block takes no new input until the pass is done.
// The sample of the last input channel closes the frame: after its pass, one
// result per cycle follows while out_ready is high, for num_outputs beats, the
// final one flagged by frame_last. When the receiver stalls, the emit sequence
// waits on the output register; after the last result is loaded the block
// takes new input while it waits. Reset clears the accumulators and runs a
// pass that zeros the gain memory; in_ready stays low during that pass,
// configuration writes are taken. The user writes configuration through
// cfg_we / cfg_index / cfg_data while idle; the block does not enforce it.
module channel_matrix_mixer_unit
    import cmm_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [CH_W-1:0]               in_channel,
    input  logic [CH_W-1:0]               out_row,
    input  logic signed [GAIN_BITS-1:0]   gain_value,
    input  logic signed [SAMPLE_BITS-1:0] sample_re,
    input  logic signed [SAMPLE_BITS-1:0] sample_im,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [CH_W-1:0]               out_channel,
    output logic signed [SAMPLE_BITS-1:0] mix_re,
    output logic signed [SAMPLE_BITS-1:0] mix_im,
    output logic                          frame_last
);

    cmd_t  cmd;
    stat_t stat;

    cmm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .in_channel (in_channel),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .stat       (stat)
    );

    cmm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_channel  (in_channel),
        .out_row     (out_row),
        .gain_value  (gain_value),
        .sample_re   (sample_re),
        .sample_im   (sample_im),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_channel (out_channel),
        .mix_re      (mix_re),
        .mix_im      (mix_im),
        .frame_last  (frame_last)
    );

endmodule

FILE: rtl/cmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/cmm_ctrl.sv
// Controller of the matrix mixer: configuration registers, sequencing state machine.
// Depends on cmm_pkg; drives the datapath through cmd_t and reads stat_t.
module cmm_ctrl
    import cmm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  func,
    input  logic [CH_W-1:0]       in_channel,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cmd_t                  cmd,
    input  stat_t                 stat
);

    logic [COUNT_W-1:0] nin_cfg_reg;
    logic [COUNT_W-1:0] nout_cfg_reg;
    logic               cmode_reg;
    logic [COUNT_W-1:0] nin_eff;
    logic [COUNT_W-1:0] nout_eff;

    state_t             state_reg, state_next;
    logic [GAIN_AW-1:0] cnt_reg, cnt_next;
    logic               last_reg, last_next;

    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                       input int hi);
        if (v == '0)
        begin
            return COUNT_W'(1);
        end
        if (int'(v) > hi)
        begin
            return COUNT_W'(hi);
        end
        return v;
    endfunction

    assign nin_eff  = clamp_count(nin_cfg_reg, IN_CHANNELS);
    assign nout_eff = clamp_count(nout_cfg_reg, OUT_CHANNELS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nin_cfg_reg  <= COUNT_W'(IN_CHANNELS);
            nout_cfg_reg <= COUNT_W'(OUT_CHANNELS);
            cmode_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_INPUTS:   nin_cfg_reg  <= cfg_data[COUNT_W-1:0];
                REG_NUM_OUTPUTS:  nout_cfg_reg <= cfg_data[COUNT_W-1:0];
                REG_COMPLEX_MODE: cmode_reg    <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        last_next        = last_reg;
        in_ready         = 1'b0;
        cmd              = '0;
        cmd.complex_mode = cmode_reg;
        cmd.row          = cnt_reg[CH_W-1:0];
        cmd.clear_addr   = cnt_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Gain store is zeroed one entry per cycle after reset.
                cmd.clear_wr = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == GAIN_AW'(GAIN_DEPTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (func == FUNC_GAIN)
                    begin
                        cmd.gain_wr = 1'b1;
                    end
                    else if ({1'b0, in_channel} < nin_eff)
                    begin
                        cmd.load_item = 1'b1;
                        last_next     = ({1'b0, in_channel} == nin_eff - 1'b1);
                        cnt_next      = '0;
                        state_next    = ST_MAC;
                    end
                end
            end
            ST_MAC:
            begin
                // Every row is accumulated, whatever the output count.
                cmd.mac_rd = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg[CH_W-1:0] == CH_W'(OUT_CHANNELS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == GAIN_AW'(DRAIN_CYCLES - 1))
                begin
                    cnt_next   = '0;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = (cnt_reg == GAIN_AW'(nout_eff - 1'b1));
                    cnt_next      = cnt_reg + 1'b1;
                    if (cmd.emit_last)
                    begin
                        cmd.acc_clear = 1'b1;
                        cnt_next      = '0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/cmm_datapath.sv
// Datapath of the matrix mixer: gain store, multiply-accumulate pipeline,
// accumulators and the output register. Depends on cmm_pkg and cmm_ram.
module cmm_datapath
    import cmm_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    output stat_t                         stat,
    input  logic [CH_W-1:0]               in_channel,
    input  logic [CH_W-1:0]               out_row,
    input  logic signed [GAIN_BITS-1:0]   gain_value,
    input  logic signed [SAMPLE_BITS-1:0] sample_re,
    input  logic signed [SAMPLE_BITS-1:0] sample_im,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [CH_W-1:0]               out_channel,
    output logic signed [SAMPLE_BITS-1:0] mix_re,
    output logic signed [SAMPLE_BITS-1:0] mix_im,
    output logic                          frame_last
);

    logic [CH_W-1:0]               col_reg;
    logic signed [SAMPLE_BITS-1:0] sre_reg;
    logic signed [SAMPLE_BITS-1:0] sim_reg;

    logic                 ram_we;
    logic [GAIN_AW-1:0]   ram_waddr;
    logic [GAIN_BITS-1:0] ram_wdata;
    logic [GAIN_BITS-1:0] ram_rdata;

    logic                        rd_v_reg;
    logic [CH_W-1:0]             rd_row_reg;
    logic signed [GAIN_BITS-1:0] gain_q;
    logic signed [PROD_BITS-1:0] mul_re;
    logic signed [PROD_BITS-1:0] mul_im;

    logic                        prod_v_reg;
    logic [CH_W-1:0]             prod_row_reg;
    logic signed [PROD_BITS-1:0] prod_re_reg;
    logic signed [PROD_BITS-1:0] prod_im_reg;

    logic signed [ACC_BITS-1:0] acc_re_reg [OUT_CHANNELS];
    logic signed [ACC_BITS-1:0] acc_im_reg [OUT_CHANNELS];

    logic                   out_valid_reg;
    logic [CH_W-1:0]        out_channel_reg;
    logic [SAMPLE_BITS-1:0] mix_re_reg;
    logic [SAMPLE_BITS-1:0] mix_im_reg;
    logic                   frame_last_reg;
    logic [SAMPLE_BITS-1:0] emit_re;
    logic [SAMPLE_BITS-1:0] emit_im;

    // Write port serves both host gain writes and the reset clearing pass.
    assign ram_we    = cmd.gain_wr | cmd.clear_wr;
    assign ram_waddr = cmd.clear_wr ? cmd.clear_addr : gain_addr(out_row, in_channel);
    assign ram_wdata = cmd.clear_wr ? '0 : gain_value;

    cmm_ram #(
        .WIDTH (GAIN_BITS),
        .DEPTH (GAIN_DEPTH)
    ) u_gain_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (gain_addr(cmd.row, col_reg)),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            col_reg <= in_channel;
            sre_reg <= sample_re;
            sim_reg <= sample_im;
        end
    end

    assign gain_q = ram_rdata;
    assign mul_re = sre_reg * gain_q;
    assign mul_im = sim_reg * gain_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg   <= cmd.mac_rd;
            prod_v_reg <= rd_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_row_reg   <= cmd.row;
        prod_row_reg <= rd_row_reg;
        prod_re_reg  <= mul_re;
        prod_im_reg  <= mul_im;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < OUT_CHANNELS; i++)
            begin
                acc_re_reg[i] <= '0;
                acc_im_reg[i] <= '0;
            end
        end
        else if (cmd.acc_clear)
        begin
            for (int i = 0; i < OUT_CHANNELS; i++)
            begin
                acc_re_reg[i] <= '0;
                acc_im_reg[i] <= '0;
            end
        end
        else if (prod_v_reg)
        begin
            acc_re_reg[prod_row_reg] <= sat_add(acc_re_reg[prod_row_reg], prod_re_reg);
            if (cmd.complex_mode)
            begin
                acc_im_reg[prod_row_reg] <= sat_add(acc_im_reg[prod_row_reg], prod_im_reg);
            end
        end
    end

    assign emit_re = to_output(acc_re_reg[cmd.row]);
    assign emit_im = cmd.complex_mode ? to_output(acc_im_reg[cmd.row]) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_channel_reg <= cmd.row;
            mix_re_reg      <= emit_re;
            mix_im_reg      <= emit_im;
            frame_last_reg  <= cmd.emit_last;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_channel   = out_channel_reg;
    assign mix_re        = mix_re_reg;
    assign mix_im        = mix_im_reg;
    assign frame_last    = frame_last_reg;

endmodule

FILE: rtl/cmm_checker.sv
// Port-level checker for the channel matrix mixer, bound to the top level.
// Depends on cmm_pkg and channel_matrix_mixer_unit_macros.svh.
`include "channel_matrix_mixer_unit_macros.svh"

module cmm_checker
    import cmm_pkg::*;
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cfg_we,
    input logic [CFG_IDX_W-1:0]          cfg_index,
    input logic [CFG_DATA_W-1:0]         cfg_data,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          func,
    input logic [CH_W-1:0]               in_channel,
    input logic [CH_W-1:0]               out_row,
    input logic signed [GAIN_BITS-1:0]   gain_value,
    input logic signed [SAMPLE_BITS-1:0] sample_re,
    input logic signed [SAMPLE_BITS-1:0] sample_im,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [CH_W-1:0]               out_channel,
    input logic signed [SAMPLE_BITS-1:0] mix_re,
    input logic signed [SAMPLE_BITS-1:0] mix_im,
    input logic                          frame_last
);

    logic            cmode_reg;
    logic [CH_W-1:0] exp_ch_reg;

    // Mirror of the complex mode register, seen from the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmode_reg <= 1'b0;
        end
        else if (cfg_we && cfg_index == REG_COMPLEX_MODE)
        begin
            cmode_reg <= cfg_data[0];
        end
    end

    // Results of a frame come in ascending channel order starting at zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_ch_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            exp_ch_reg <= frame_last ? '0 : exp_ch_reg + 1'b1;
        end
    end

    `CMM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_channel) && $stable(mix_re) && $stable(mix_im) && $stable(frame_last), "result beat changed while stalled")
    `CMM_ASSERT(a_out_order, out_valid |-> out_channel == exp_ch_reg, "result channel out of order")
    `CMM_ASSERT(a_top_last, out_valid && out_channel == CH_W'(OUT_CHANNELS - 1) |-> frame_last, "highest channel not marked last")
    `CMM_NEVER(a_real_im, out_valid && !cmode_reg && mix_im != '0, "imaginary output nonzero in real mode")

endmodule

bind channel_matrix_mixer_unit cmm_checker u_cmm_checker (.*);

FILE: sim/tb_channel_matrix_mixer_unit.sv
// Self-checking testbench for channel_matrix_mixer_unit: gain writes and sample beats go in,
// and a shadow model of the gain matrix and accumulators predicts every mixed output beat.
// Depends on cmm_pkg and the channel_matrix_mixer_unit RTL only.
`timescale 1ns / 100ps

module tb_channel_matrix_mixer_unit;

    import cmm_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 16;
    localparam int END_WAIT    = 32;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [GAIN_BITS-1:0]   GAIN_MAX   = {1'b0, {(GAIN_BITS-1){1'b1}}};
    localparam logic signed [GAIN_BITS-1:0]   GAIN_MIN   = {1'b1, {(GAIN_BITS-1){1'b0}}};

    typedef struct {
        logic                          func;
        logic [CH_W-1:0]               in_channel;
        logic [CH_W-1:0]               out_row;
        logic signed [GAIN_BITS-1:0]   gain_value;
        logic signed [SAMPLE_BITS-1:0] sample_re;
        logic signed [SAMPLE_BITS-1:0] sample_im;
    } mixer_item_t;

    typedef struct {
        logic [CH_W-1:0]               out_channel;
        logic signed [SAMPLE_BITS-1:0] mix_re;
        logic signed [SAMPLE_BITS-1:0] mix_im;
        logic                          frame_last;
    } mix_beat_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          func = 1'b0;
    logic [CH_W-1:0]               in_channel = '0;
    logic [CH_W-1:0]               out_row = '0;
    logic signed [GAIN_BITS-1:0]   gain_value = '0;
    logic signed [SAMPLE_BITS-1:0] sample_re = '0;
    logic signed [SAMPLE_BITS-1:0] sample_im = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [CH_W-1:0]               out_channel;
    logic signed [SAMPLE_BITS-1:0] mix_re;
    logic signed [SAMPLE_BITS-1:0] mix_im;
    logic                          frame_last;

    // Shadow copy of the block state and its configuration registers.
    logic signed [GAIN_BITS-1:0] shadow_gain [GAIN_DEPTH] = '{default: '0};
    logic signed [ACC_BITS-1:0]  shadow_acc_re [OUT_CHANNELS] = '{default: '0};
    logic signed [ACC_BITS-1:0]  shadow_acc_im [OUT_CHANNELS] = '{default: '0};
    logic [COUNT_W-1:0]          shadow_nin = 4'd8;
    logic [COUNT_W-1:0]          shadow_nout = 4'd8;
    logic                        shadow_cplx = 1'b0;

    mix_beat_t pending_mix [$];
    mix_beat_t want_beat;
    int        error_count = 0;
    int        items_effective = 0;
    int        snd_idle_pct = 11;
    int        rcv_idle_pct = 57;

    channel_matrix_mixer_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .in_channel  (in_channel),
        .out_row     (out_row),
        .gain_value  (gain_value),
        .sample_re   (sample_re),
        .sample_im   (sample_im),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_channel (out_channel),
        .mix_re      (mix_re),
        .mix_im      (mix_im),
        .frame_last  (frame_last)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    function automatic int eff_count(input logic [COUNT_W-1:0] v, input int hi);
        if (v == 0)
            return 1;
        if (int'(v) > hi)
            return hi;
        return int'(v);
    endfunction

    function automatic logic signed [ACC_BITS-1:0] acc_plus(input logic signed [ACC_BITS-1:0] acc,
                                                            input longint prod);
        longint s;
        longint hi;
        hi = (longint'(1) <<< (ACC_BITS - 1)) - 1;
        s  = longint'(acc) + prod;
        if (s > hi)
            s = hi;
        else if (s < -hi - 1)
            s = -hi - 1;
        return s[ACC_BITS-1:0];
    endfunction

    // Round half up by the gain fraction, then clip to the sample range.
    function automatic logic signed [SAMPLE_BITS-1:0] round_out(
        input logic signed [ACC_BITS-1:0] acc);
        longint r;
        longint top;
        top = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        r   = (longint'(acc) + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > top)
            r = top;
        else if (r < -top - 1)
            r = -top - 1;
        return r[SAMPLE_BITS-1:0];
    endfunction

    task automatic predict_mix(input mixer_item_t it);
        int        nin;
        int        nout;
        int        col;
        mix_beat_t b;
        nin  = eff_count(shadow_nin, IN_CHANNELS);
        nout = eff_count(shadow_nout, OUT_CHANNELS);
        col  = int'(it.in_channel);
        if (it.func == FUNC_GAIN)
        begin
            shadow_gain[int'(it.out_row) * IN_CHANNELS + col] = it.gain_value;
            items_effective++;
        end
        else if (col < nin)
        begin
            items_effective++;
            for (int j = 0; j < OUT_CHANNELS; j++)
            begin
                shadow_acc_re[j] = acc_plus(shadow_acc_re[j], longint'(it.sample_re) *
                                            longint'(shadow_gain[j * IN_CHANNELS + col]));
                if (shadow_cplx)
                    shadow_acc_im[j] = acc_plus(shadow_acc_im[j], longint'(it.sample_im) *
                                                longint'(shadow_gain[j * IN_CHANNELS + col]));
            end
            // The last configured channel closes the frame.
            if (col == nin - 1)
            begin
                for (int j = 0; j < nout; j++)
                begin
                    b.out_channel = CH_W'(j);
                    b.mix_re      = round_out(shadow_acc_re[j]);
                    b.mix_im      = shadow_cplx ? round_out(shadow_acc_im[j]) : '0;
                    b.frame_last  = (j == nout - 1);
                    pending_mix.push_back(b);
                end
                for (int j = 0; j < OUT_CHANNELS; j++)
                begin
                    shadow_acc_re[j] = '0;
                    shadow_acc_im[j] = '0;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("%0t MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
        error_count++;
    endtask

    // Output beats are judged at the falling edge, where valid and ready are settled.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_mix.size() == 0)
                report_mismatch("beat with nothing pending, out_channel", -1, out_channel);
            else
            begin
                want_beat = pending_mix.pop_front();
                if (out_channel !== want_beat.out_channel)
                    report_mismatch("out_channel", want_beat.out_channel, out_channel);
                if (mix_re !== want_beat.mix_re)
                    report_mismatch("mix_re", want_beat.mix_re, mix_re);
                if (mix_im !== want_beat.mix_im)
                    report_mismatch("mix_im", want_beat.mix_im, mix_im);
                if (frame_last !== want_beat.frame_last)
                    report_mismatch("frame_last", want_beat.frame_last, frame_last);
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Called in a rising-edge time step; returns in the step of the accepting edge.
    task automatic send_item(input mixer_item_t it);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= it.func;
        in_channel <= it.in_channel;
        out_row    <= it.out_row;
        gain_value <= it.gain_value;
        sample_re  <= it.sample_re;
        sample_im  <= it.sample_im;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        predict_mix(it);
    endtask

    task automatic settle_block(input int hold);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_mix.size() != 0)
            @(posedge clk);
        repeat (hold) @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] nin, input logic [CFG_DATA_W-1:0] nout,
                              input logic [CFG_DATA_W-1:0] cplx);
        cfg_we    <= 1'b1;
        cfg_index <= REG_NUM_INPUTS;
        cfg_data  <= nin;
        @(posedge clk);
        cfg_index <= REG_NUM_OUTPUTS;
        cfg_data  <= nout;
        @(posedge clk);
        cfg_index <= REG_COMPLEX_MODE;
        cfg_data  <= cplx;
        @(posedge clk);
        cfg_we      <= 1'b0;
        shadow_nin  = nin;
        shadow_nout = nout;
        shadow_cplx = cplx[0];
    endtask

    function automatic mixer_item_t gain_item(input int row, input int col,
                                              input logic signed [GAIN_BITS-1:0] value);
        mixer_item_t it;
        it.func       = FUNC_GAIN;
        it.in_channel = CH_W'(col);
        it.out_row    = CH_W'(row);
        it.gain_value = value;
        it.sample_re  = SAMPLE_BITS'($urandom);
        it.sample_im  = SAMPLE_BITS'($urandom);
        return it;
    endfunction

    function automatic mixer_item_t sample_item(input int ch,
                                                input logic signed [SAMPLE_BITS-1:0] re,
                                                input logic signed [SAMPLE_BITS-1:0] im);
        mixer_item_t it;
        it.func       = FUNC_SAMPLE;
        it.in_channel = CH_W'(ch);
        it.out_row    = CH_W'($urandom);
        it.gain_value = GAIN_BITS'($urandom);
        it.sample_re  = re;
        it.sample_im  = im;
        return it;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return SAMPLE_BITS'(int'($urandom_range(4095)) - 2048);
            4:       return SAMPLE_BITS'(int'($urandom_range(1 << 20)) - (1 << 19));
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic signed [GAIN_BITS-1:0] rand_gain();
        case ($urandom_range(7))
            0:          return GAIN_MAX;
            1:          return GAIN_MIN;
            2, 3, 4:    return GAIN_BITS'(int'($urandom_range(32768)) - 16384);
            default:    return GAIN_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_count();
        if ($urandom_range(5) == 0)
            return CFG_DATA_W'($urandom_range(15));
        return CFG_DATA_W'($urandom_range(1, 8));
    endfunction

    // Defaults after reset: eight inputs, eight outputs, real mode, all gains zero.
    task automatic test_reset_state();
        send_item(sample_item(7, SAMPLE_MAX, SAMPLE_MIN));
    endtask

    task automatic test_gain_extremes();
        logic signed [GAIN_BITS-1:0] probe [OUT_CHANNELS];
        probe = '{GAIN_MIN, GAIN_MAX, 16384, -16384, 0, 1, -1, 8192};
        settle_block(DRAIN_WAIT);
        set_config(4'd1, 4'd8, 4'd1);
        for (int r = 0; r < OUT_CHANNELS; r++)
            send_item(gain_item(r, 0, probe[r]));
        send_item(sample_item(0, SAMPLE_MAX, SAMPLE_MIN));
        // A half step rounds up on the positive side and to zero on the negative.
        send_item(sample_item(0, 1, -1));
        send_item(sample_item(0, SAMPLE_MIN, SAMPLE_MAX));
    endtask

    task automatic test_frame_order();
        settle_block(DRAIN_WAIT);
        set_config(4'd3, 4'd2, 4'd0);
        send_item(gain_item(0, 1, 16384));
        send_item(gain_item(1, 2, -16384));
        // Only the last channel: the missing ones add nothing.
        send_item(sample_item(2, 24'sd1000, 24'sd77));
        send_item(sample_item(1, 24'sd300000, -24'sd5));
        send_item(sample_item(1, -24'sd100000, 24'sd5));
        send_item(sample_item(5, SAMPLE_MAX, SAMPLE_MAX));
        send_item(sample_item(0, SAMPLE_MIN, SAMPLE_MIN));
        send_item(sample_item(2, 24'sd4096, -24'sd4096));
    endtask

    task automatic test_mode_switch();
        settle_block(DRAIN_WAIT);
        set_config(4'd2, 4'd3, 4'd1);
        send_item(sample_item(0, 24'sd200000, -24'sd300000));
        settle_block(DRAIN_WAIT);
        // Only bit zero of the data selects the mode.
        set_config(4'd2, 4'd3, 4'b1110);
        send_item(sample_item(1, -24'sd12345, 24'sd54321));
        send_item(sample_item(0, 24'sd700000, 24'sd900000));
        settle_block(DRAIN_WAIT);
        set_config(4'd2, 4'd3, 4'd1);
        send_item(sample_item(1, 24'sd11, -24'sd600000));
    endtask

    task automatic test_register_limits();
        settle_block(DRAIN_WAIT);
        // Zero counts as one input; fifteen outputs clip to the matrix height.
        set_config(4'd0, 4'd15, 4'd1);
        send_item(sample_item(0, SAMPLE_MAX, SAMPLE_MAX));
        send_item(sample_item(1, SAMPLE_MAX, SAMPLE_MAX));
        settle_block(DRAIN_WAIT);
        set_config(4'd15, 4'd0, 4'd0);
        send_item(sample_item(7, SAMPLE_MIN, SAMPLE_MAX));
    endtask

    // Drive the accumulators past their range, then back, so clipping shows at the output.
    task automatic test_accumulator_saturation();
        settle_block(DRAIN_WAIT);
        set_config(4'd2, 4'd2, 4'd1);
        send_item(gain_item(0, 0, GAIN_MIN));
        send_item(gain_item(1, 0, GAIN_MAX));
        repeat (17) send_item(sample_item(0, SAMPLE_MIN, SAMPLE_MAX));
        repeat (16) send_item(sample_item(0, SAMPLE_MAX, SAMPLE_MIN));
        send_item(sample_item(1, 24'sd0, 24'sd0));
    endtask

    task automatic random_frame();
        int nin;
        nin = eff_count(shadow_nin, IN_CHANNELS);
        repeat ($urandom_range(0, 3))
            send_item(gain_item($urandom_range(7), $urandom_range(7), rand_gain()));
        if ($urandom_range(9) < 8)
        begin
            for (int k = 0; k < nin; k++)
            begin
                if ($urandom_range(15) == 0)
                    send_item(gain_item($urandom_range(7), $urandom_range(7), rand_gain()));
                send_item(sample_item(k, rand_sample(), rand_sample()));
            end
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                send_item(sample_item($urandom_range(7), rand_sample(), rand_sample()));
        end
        if ($urandom_range(7) == 0)
            settle_block(0);
    endtask

    task automatic random_phase(input int snd_pct, input int rcv_pct, input int item_goal);
        int first;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        first = items_effective;
        while (items_effective - first < item_goal)
        begin
            settle_block(DRAIN_WAIT);
            set_config(rand_count(), rand_count(), CFG_DATA_W'($urandom));
            repeat ($urandom_range(2, 5)) random_frame();
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_gain_extremes();
        test_frame_order();
        test_mode_switch();
        test_register_limits();
        test_accumulator_saturation();
        random_phase(11, 57, 85);
        random_phase(57, 11, 85);
        random_phase(0, 0, 85);
        settle_block(END_WAIT);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: channel_matrix_mixer_unit.f
+incdir+rtl
rtl/cmm_pkg.sv
rtl/cmm_ram.sv
rtl/cmm_ctrl.sv
rtl/cmm_datapath.sv
rtl/channel_matrix_mixer_unit.sv
rtl/cmm_checker.sv
sim/tb_channel_matrix_mixer_unit.sv
